FILE: rtl/core/pes_pkg.sv
// Package with types and constants shared by the particle energy statistics block.
package pes_pkg;

    localparam int unsigned MaxParticles = 1048576;
    localparam int unsigned CountFieldMax = 2097151;
    localparam logic [20:0] CountLimit = (MaxParticles > CountFieldMax) ?
        21'(CountFieldMax) : 21'(MaxParticles);

    // floor(x / 5) is (x * RecipFive) >> 66 for any 64-bit x.
    localparam logic [63:0] RecipFive = 64'hCCCC_CCCC_CCCC_CCCD;
    // floor(2^64 / 10); the remainder of 2^64 by ten is six.
    localparam logic [63:0] TenthOfTwo64 = 64'd1844674407370955161;

    typedef enum logic [1:0] {
        MODE_TRANS_ENERGY = 2'd0,
        MODE_ROT_ENERGY   = 2'd1,
        MODE_SPEED        = 2'd2,
        MODE_SPIN_SPEED   = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_STATISTIC_MODE = 1'b0,
        CFG_THREE_DIM      = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] spin_x;
        logic signed [31:0] spin_y;
        logic signed [31:0] spin_z;
        logic [31:0]        particle_mass;
        logic [31:0]        particle_diameter;
        logic               last_particle;
    } t_in_item;

    typedef struct packed {
        logic [63:0] total_sum;
        logic [63:0] largest_value;
        logic [63:0] smallest_value;
        logic [63:0] mean_value;
        logic        saturated;
    } t_out_item;

    // Work handed from the front part to the value unit.
    typedef struct packed {
        t_mode       mode;
        logic [63:0] vsq;
        logic [63:0] wsq;
        logic [31:0] mass;
        logic [31:0] diam;
        logic        last;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SQRT,
        ST_ACC,
        ST_MEAN,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/core/pes_front.sv
// Front part: squares and sums the vector components of an accepted particle.
module pes_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pes_pkg::t_in_item i_item,
    input  logic [1:0]        i_mode,
    input  logic              i_three_dim,
    output logic              o_valid,
    output pes_pkg::t_job     o_job,
    input  logic              i_ready,
    output logic              o_ready
);
    import pes_pkg::*;

    logic          r_valid;
    t_job          r_job;
    logic [31:0]   mag [6];
    logic [63:0]   sq [6];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job = r_job;

    always_comb begin
        mag[0] = i_item.vel_x[31] ? 32'(-i_item.vel_x) : i_item.vel_x;
        mag[1] = i_item.vel_y[31] ? 32'(-i_item.vel_y) : i_item.vel_y;
        mag[2] = i_item.vel_z[31] ? 32'(-i_item.vel_z) : i_item.vel_z;
        mag[3] = i_item.spin_x[31] ? 32'(-i_item.spin_x) : i_item.spin_x;
        mag[4] = i_item.spin_y[31] ? 32'(-i_item.spin_y) : i_item.spin_y;
        mag[5] = i_item.spin_z[31] ? 32'(-i_item.spin_z) : i_item.spin_z;
        for (int k = 0; k < 6; k++) begin
            sq[k] = {32'd0, mag[k]} * {32'd0, mag[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job.mode <= t_mode'(i_mode);
            r_job.vsq  <= sq[0] + sq[1] + (i_three_dim ? sq[2] : 64'd0);
            r_job.wsq  <= sq[5] + (i_three_dim ? sq[3] + sq[4] : 64'd0);
            r_job.mass <= i_item.particle_mass;
            r_job.diam <= i_item.particle_diameter;
            r_job.last <= i_item.last_particle;
        end
    end

endmodule

FILE: rtl/core/pes_queue.sv
// Two-entry queue between the front part and the back part.
module pes_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pes_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pes_pkg::t_job o_data
);
    import pes_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) r_wptr <= !r_wptr;
            if (do_pop) r_rptr <= !r_rptr;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) r_mem[r_wptr] <= i_data;
    end

endmodule

FILE: rtl/core/pes_back.sv
// Back part: computes the value, accumulates statistics and emits results.
module pes_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  pes_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_empty,
    output pes_pkg::t_out_item o_item,
    input  logic               i_pop
);
    import pes_pkg::*;

    t_state        r_state, n_state;
    t_job          r_job;
    logic [5:0]    r_step;
    logic [159:0]  r_prod;
    logic [95:0]   r_ma;
    logic [63:0]   r_mb;
    logic [63:0]   r_hiq;
    logic [63:0]   r_value;
    logic          r_vsat;
    logic [63:0]   r_rem;
    logic [63:0]   r_quo;
    logic [63:0]   r_sum;
    logic [63:0]   r_max;
    logic [63:0]   r_min;
    logic [20:0]   r_cnt;
    logic          r_sat;
    t_out_item     r_out;
    logic          r_out_valid;

    // Square root working registers.
    logic [97:0]   r_srem;
    logic [63:0]   r_sroot;
    logic [97:0]   r_sdat;

    logic          take;
    logic [64:0]   sum_ext;
    logic [64:0]   qtry;
    logic [99:0]   strial;
    logic [99:0]   srem_sh;
    logic [2:0]    pp_k;
    logic [31:0]   pp_a;
    logic [31:0]   pp_b;
    logic [63:0]   pp;
    logic [1:0]    pp_sh_amt;
    logic [159:0]  pp_sh;
    logic [63:0]   hi_q;
    logic [64:0]   div_w;

    assign o_empty = !r_out_valid;
    assign o_item = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_empty) begin
                n_state = (i_job.mode == MODE_SPEED || i_job.mode == MODE_SPIN_SPEED) ?
                    ST_SQRT : ST_MUL;
            end
            ST_MUL: begin
                if (r_job.mode == MODE_ROT_ENERGY) begin
                    if (r_step == 6'd14) n_state = ST_DIV;
                end else if (r_step == 6'd7) begin
                    n_state = ST_ACC;
                end
            end
            ST_DIV:  if (r_step == 6'd6) n_state = ST_ACC;
            ST_SQRT: if (r_step == 6'd48) n_state = ST_ACC;
            ST_ACC:  n_state = r_job.last ? ST_MEAN : ST_IDLE;
            ST_MEAN: if (r_step == 6'd63) n_state = ST_OUT;
            ST_OUT:  if (!r_out_valid) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        take = (r_state == ST_IDLE) && !i_empty;
        o_pop = take;
    end

    // One 32 by 32 partial product a cycle, added at its word offset.
    always_comb begin
        if (r_state == ST_DIV) pp_k = r_step[2:0];
        else if (r_step >= 6'd8) pp_k = 3'(r_step - 6'd8);
        else pp_k = 3'(r_step - 6'd1);
        case (pp_k[2:1])
            2'd0:    pp_a = r_ma[31:0];
            2'd1:    pp_a = r_ma[63:32];
            default: pp_a = r_ma[95:64];
        endcase
        pp_b = pp_k[0] ? r_mb[63:32] : r_mb[31:0];
        pp = {32'd0, pp_a} * {32'd0, pp_b};
        pp_sh_amt = pp_k[2:1] + {1'b0, pp_k[0]};
        case (pp_sh_amt)
            2'd0:    pp_sh = {96'd0, pp};
            2'd1:    pp_sh = {64'd0, pp, 32'd0};
            2'd2:    pp_sh = {32'd0, pp, 64'd0};
            default: pp_sh = {pp, 96'd0};
        endcase
    end

    // The product shifted down by 48 is hi * 2^64 + lo; hi times floor(2^64 / 10) is
    // added to floor((6 * hi + lo) / 10).
    assign hi_q = (r_prod[112] ? TenthOfTwo64 : 64'd0)
        + (r_prod[113] ? {TenthOfTwo64[62:0], 1'b0} : 64'd0)
        + (r_prod[114] ? {TenthOfTwo64[61:0], 2'b00} : 64'd0)
        + (r_prod[115] ? {TenthOfTwo64[60:0], 3'b000} : 64'd0);
    assign div_w = {1'b0, r_prod[111:48]} + {60'd0, r_prod[115:112], 1'b0}
        + {59'd0, r_prod[115:112], 2'b00};

    assign sum_ext = {1'b0, r_sum} + {1'b0, r_value};
    assign qtry = {r_rem, r_quo[63]} - {44'd0, r_cnt};
    assign srem_sh = {r_srem, r_sdat[97:96]};
    assign strial = srem_sh - {34'd0, r_sroot, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_max       <= '0;
            r_min       <= '1;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_pop) r_out_valid <= 1'b0;
            if (r_state == ST_ACC) begin
                if (sum_ext[64]) r_sum <= '1;
                else r_sum <= sum_ext[63:0];
                if (r_value > r_max) r_max <= r_value;
                if (r_value < r_min) r_min <= r_value;
                if (r_cnt < CountLimit) r_cnt <= r_cnt + 21'd1;
                if (r_vsat || sum_ext[64] || !(r_cnt < CountLimit)) r_sat <= 1'b1;
            end
            if (r_state == ST_MEAN && r_step == 6'd63) begin
                r_out_valid <= 1'b1;
                r_sum <= '0;
                r_max <= '0;
                r_min <= '1;
                r_cnt <= '0;
                r_sat <= 1'b0;
            end
        end
        r_step <= (r_state != n_state) ? 6'd0 : r_step + 6'd1;
        if (take) begin
            r_job  <= i_job;
            r_vsat <= 1'b0;
            r_prod <= '0;
            r_srem <= '0;
            r_sroot <= '0;
            r_sdat <= (i_job.mode == MODE_SPEED) ? {i_job.vsq, 34'd0} :
                {i_job.wsq, 34'd0};
        end
        unique case (r_state)
            ST_MUL: begin
                // Product chain: mass*vsq, or mass*diam*diam*wsq, in multiword passes.
                if (r_step == 6'd0) begin
                    r_prod <= '0;
                    if (r_job.mode == MODE_ROT_ENERGY) begin
                        r_ma <= {32'd0, {32'd0, r_job.mass} * {32'd0, r_job.diam}};
                        r_mb <= {32'd0, r_job.diam};
                    end else begin
                        r_ma <= {64'd0, r_job.mass};
                        r_mb <= r_job.vsq;
                    end
                end else if (r_step == 6'd7 && r_job.mode == MODE_ROT_ENERGY) begin
                    r_prod <= '0;
                    r_ma <= r_prod[95:0];
                    r_mb <= r_job.wsq;
                end else if (r_step == 6'd7) begin
                    r_vsat <= |r_prod[159:81];
                    r_value <= (|r_prod[159:81]) ? '1 : r_prod[80:17];
                end else if (r_step == 6'd14) begin
                    r_vsat <= (r_prod[159:112] >= 48'd10);
                    r_hiq <= hi_q;
                    r_prod <= '0;
                    r_ma <= {32'd0, div_w[64:1]};
                    r_mb <= RecipFive;
                end else begin
                    r_prod <= r_prod + pp_sh;
                end
            end
            ST_DIV: begin
                if (r_step == 6'd6) begin
                    r_value <= r_vsat ? '1 : r_hiq + {2'd0, r_prod[127:66]};
                end else begin
                    r_prod <= r_prod + pp_sh;
                end
            end
            ST_SQRT: begin
                if (r_step != 6'd48) begin
                    r_sdat <= {r_sdat[95:0], 2'b00};
                    if (!strial[99]) begin
                        r_srem <= strial[97:0];
                        r_sroot <= {r_sroot[62:0], 1'b1};
                    end else begin
                        r_srem <= srem_sh[97:0];
                        r_sroot <= {r_sroot[62:0], 1'b0};
                    end
                end else begin
                    r_value <= r_sroot;
                end
            end
            ST_ACC: begin
                r_rem <= '0;
                r_quo <= sum_ext[64] ? '1 : sum_ext[63:0];
            end
            ST_MEAN: begin
                if (!qtry[64]) begin
                    r_rem <= qtry[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], r_quo[63]};
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                if (r_step == 6'd63) begin
                    r_out.total_sum      <= r_sum;
                    r_out.largest_value  <= r_max;
                    r_out.smallest_value <= r_min;
                    r_out.mean_value     <= {r_quo[62:0], !qtry[64]};
                    r_out.saturated      <= r_sat;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/particle_energy_statistics_top.sv
// Top level of the particle energy statistics block.
// An accepted item is registered in the front part and queued; the back part then forms its
// value by multiword products for translational energy, products and a division by ten for
// rotational energy, or a square root for speeds, and accumulates it; a last particle adds the
// mean division before its result shows. The back part takes a new item only when idle.
// Reset is synchronous and active low; it clears the accumulators and the queue.
module particle_energy_statistics_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pes_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output pes_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [1:0]         i_cfg_data
);
    import pes_pkg::*;

    logic [1:0] r_mode;
    logic       r_three_dim;
    logic       f_valid, f_ready, q_full, q_empty, q_pop;
    t_job       f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 2'd0;
            r_three_dim <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_STATISTIC_MODE: r_mode <= i_cfg_data;
                CFG_THREE_DIM:      r_three_dim <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign full = !f_ready;

    pes_front u_front (
        .i_clk, .i_rst_n, .i_valid(push), .i_item, .i_mode(r_mode),
        .i_three_dim(r_three_dim), .o_valid(f_valid), .o_job(f_job),
        .i_ready(!q_full), .o_ready(f_ready)
    );

    pes_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_data(f_job), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(q_job)
    );

    pes_back u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_job(q_job), .o_pop(q_pop),
        .o_empty(empty), .o_item, .i_pop(pop)
    );

endmodule

FILE: tb/sv/particle_energy_statistics_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the particle energy statistics block, with its own predictor.
module particle_energy_statistics_top_tb;
    import pes_pkg::*;

    localparam int unsigned WatchdogLimit = 20000;
    localparam int unsigned DrainCycles = 200;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_item;
    logic      i_cfg_we;
    logic      i_cfg_index;
    logic [1:0] i_cfg_data;

    particle_energy_statistics_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    t_mode       stat_mode;
    logic        use_3d;
    logic [63:0] run_sum;
    logic [63:0] run_max;
    logic [63:0] run_min;
    logic [20:0] run_count;
    logic        run_sat;

    t_out_item   pending_stats[$];
    int unsigned error_count;
    int unsigned particles_sent;
    int unsigned sets_checked;
    int unsigned idle_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] square_q(logic signed [31:0] comp);
        logic [63:0] mag;
        mag = comp[31] ? 64'(-$signed({comp[31], comp})) : 64'(comp);
        return mag * mag;
    endfunction

    function automatic logic [63:0] root_q(logic [63:0] s);
        logic [127:0] target;
        logic [63:0]  r;
        logic [63:0]  c;
        target = {32'd0, s, 32'd0};
        r = '0;
        for (int b = 47; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= target) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] particle_value(t_in_item p, output logic sat);
        logic [63:0]  vsq;
        logic [63:0]  wsq;
        logic [191:0] wide;
        sat = 1'b0;
        vsq = square_q(p.vel_x) + square_q(p.vel_y) + (use_3d ? square_q(p.vel_z) : 64'd0);
        wsq = square_q(p.spin_z) + (use_3d ? square_q(p.spin_x) + square_q(p.spin_y) : 64'd0);
        case (stat_mode)
            MODE_TRANS_ENERGY: begin
                wide = (192'(p.particle_mass) * 192'(vsq)) >> 17;
            end
            MODE_ROT_ENERGY: begin
                wide = 192'(p.particle_mass) * 192'(64'(p.particle_diameter)
                    * 64'(p.particle_diameter)) * 192'(wsq);
                wide = (wide / 192'd10) >> 48;
            end
            MODE_SPEED: return root_q(vsq);
            default: return root_q(wsq);
        endcase
        if (wide[191:64] != '0) begin
            sat = 1'b1;
            return '1;
        end
        return wide[63:0];
    endfunction

    task automatic clear_stats();
        run_sum = '0;
        run_max = '0;
        run_min = '1;
        run_count = '0;
        run_sat = 1'b0;
    endtask

    task automatic predict_particle(t_in_item p);
        logic [63:0] v;
        logic        sat;
        t_out_item   res;
        v = particle_value(p, sat);
        if (run_sum > ~v) begin
            run_sum = '1;
            sat = 1'b1;
        end else begin
            run_sum = run_sum + v;
        end
        if (v > run_max) run_max = v;
        if (v < run_min) run_min = v;
        if (run_count < CountLimit) run_count++;
        else sat = 1'b1;
        run_sat |= sat;
        if (p.last_particle) begin
            res.total_sum = run_sum;
            res.largest_value = run_max;
            res.smallest_value = run_min;
            res.mean_value = run_sum / 64'(run_count);
            res.saturated = run_sat;
            pending_stats.push_back(res);
            clear_stats();
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (pop && !empty) begin
                if (pending_stats.size() == 0) begin
                    report_mismatch("unexpected transaction", 64'(o_item.total_sum), 64'd0);
                end else begin
                    want = pending_stats.pop_front();
                    sets_checked++;
                    if (o_item.total_sum !== want.total_sum)
                        report_mismatch("total_sum", o_item.total_sum, want.total_sum);
                    if (o_item.largest_value !== want.largest_value)
                        report_mismatch("largest_value", o_item.largest_value,
                            want.largest_value);
                    if (o_item.smallest_value !== want.smallest_value)
                        report_mismatch("smallest_value", o_item.smallest_value,
                            want.smallest_value);
                    if (o_item.mean_value !== want.mean_value)
                        report_mismatch("mean_value", o_item.mean_value, want.mean_value);
                    if (o_item.saturated !== want.saturated)
                        report_mismatch("saturated", 64'(o_item.saturated),
                            64'(want.saturated));
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WatchdogLimit) begin
            $display("timeout with %0d transactions outstanding", pending_stats.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_particle(t_in_item p);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_particle(p);
        particles_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [1:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_STATISTIC_MODE) stat_mode = t_mode'(data);
        else use_3d = data[0];
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(2)) - 32'd1;
            3: return 32'($signed(16'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_particle(bit last);
        t_in_item p;
        p.vel_x = rand_field();
        p.vel_y = rand_field();
        p.vel_z = rand_field();
        p.spin_x = rand_field();
        p.spin_y = rand_field();
        p.spin_z = rand_field();
        p.particle_mass = ($urandom_range(3) == 0) ? rand_field() : $urandom_range(32'h4_0000);
        p.particle_diameter = ($urandom_range(3) == 0) ? rand_field() : $urandom_range(32'h2_0000);
        p.last_particle = last;
        return p;
    endfunction

    task automatic test_directed_extremes();
        t_in_item p;
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_STATISTIC_MODE, 2'(m));
            for (int d = 0; d < 2; d++) begin
                write_reg(CFG_THREE_DIM, 2'(d));
                p = '0;
                p.last_particle = 1'b1;
                send_particle(p);
                p = '1;
                p.vel_x = 32'sh8000_0000;
                p.spin_z = 32'sh8000_0000;
                p.last_particle = 1'b0;
                send_particle(p);
                p.vel_y = 32'sh7fff_ffff;
                p.spin_x = 32'sh7fff_ffff;
                p.last_particle = 1'b1;
                send_particle(p);
            end
        end
    endtask

    task automatic test_random_sets(int unsigned n_items);
        int unsigned sent;
        int unsigned set_len;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 40 == 0) begin
                write_reg(CFG_STATISTIC_MODE, 2'($urandom_range(3)));
                write_reg(CFG_THREE_DIM, 2'($urandom_range(1)));
            end
            set_len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(1, 6);
            for (int i = 0; i < set_len; i++) begin
                send_particle(rand_particle(i == set_len - 1));
            end
            sent += set_len;
        end
    endtask

    task automatic test_pause_until_drained();
        send_particle(rand_particle(1'b1));
        push <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        send_particle(rand_particle(1'b1));
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_STATISTIC_MODE;
        i_cfg_data = '0;
        error_count = 0;
        particles_sent = 0;
        sets_checked = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stat_mode = MODE_TRANS_ENERGY;
        use_3d = 1'b1;
        clear_stats();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_random_sets(330);
        send_idle_pct = 60;
        test_random_sets(330);
        send_idle_pct = 0;
        recv_stall_pct = 60;
        test_random_sets(330);
        send_idle_pct = 10;
        recv_stall_pct = 10;
        test_pause_until_drained();
        test_random_sets(330);
        wait_drained();
        $display("Sent %0d particles over all four statistics in 2D and 3D.", particles_sent);
        $display("Checked %0d set summaries under varied idle and stall patterns.",
            sets_checked);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
